@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timer unit RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a trigger is followed in the next cycle by a consequence.
`define MCST_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mcst_pkg.sv @@
// Package for the multi-channel timer unit: mode codes, payload structs,
// and the control/status bundles between the top level and the slot cells.
package mcst_pkg;

  localparam int DEF_NUM_TIMERS  = 16;
  localparam int DEF_COUNT_WIDTH = 32;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_CONFIG    = 3'd1,
    MODE_START     = 3'd2,
    MODE_START_IVL = 3'd3,
    MODE_STOP      = 3'd4,
    MODE_RESTART   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [31:0] interval;
    logic        periodic;
  } in_item_t;

  typedef struct packed {
    logic [3:0] expired_slot;
    logic       last;
    logic [4:0] running_count;
  } out_item_t;

  // Broadcast to every cell: tick strobe plus an addressed command.
  typedef struct packed {
    logic        tick;
    logic        sel;
    logic [2:0]  mode;
    logic [31:0] interval;
    logic        periodic;
  } cell_cmd_t;

  // What one cell reports back to the controller.
  typedef struct packed {
    logic running;
    logic pending;
    logic reload_zero;
    logic periodic;
  } cell_status_t;

endpackage

@@ rtl/core/mcst_cell.sv @@
// One timer slot of the chain: countdown, reload interval, flags and
// the scan token that walks the row. Depends on mcst_pkg.
module mcst_cell #(
  parameter int COUNT_WIDTH = mcst_pkg::DEF_COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcst_pkg::cell_cmd_t      cmd,
  input  logic                     tok_in,
  input  logic                     shift,
  output logic                     tok_out,
  output mcst_pkg::cell_status_t   status
);
  import mcst_pkg::*;

  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] rel_r, rel_nxt;
  logic                   rep_r, rep_nxt;
  logic                   run_r, run_nxt;
  logic                   tok_r, tok_nxt;
  logic [COUNT_WIDTH-1:0] ivl;
  logic                   pend;

  assign ivl  = COUNT_WIDTH'(cmd.interval);
  assign pend = run_r && (rem_r == '0);

  // Decrement, command, and expiry service for this slot
  always_comb begin
    rem_nxt = rem_r;
    rel_nxt = rel_r;
    rep_nxt = rep_r;
    run_nxt = run_r;
    tok_nxt = shift ? tok_in : tok_r;

    if (cmd.tick && run_r) begin
      rem_nxt = rem_r - 1'b1;
    end

    if (cmd.sel) begin
      case (cmd.mode)
        MODE_CONFIG: begin
          rel_nxt = ivl;
          rep_nxt = cmd.periodic;
        end
        MODE_START: begin
          if (rel_r != '0 && !run_r) begin
            rem_nxt = rel_r;
            run_nxt = 1'b1;
          end
        end
        MODE_START_IVL: begin
          rel_nxt = ivl;
          if (ivl != '0 && !run_r) begin
            rem_nxt = ivl;
            run_nxt = 1'b1;
          end
        end
        MODE_STOP: begin
          run_nxt = 1'b0;
          rem_nxt = '0;
        end
        MODE_RESTART: begin
          if (rel_r != '0) begin
            rem_nxt = rel_r;
            run_nxt = 1'b1;
          end else begin
            run_nxt = 1'b0;
            rem_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end

    // Reload a periodic slot, drop a one-shot slot, when the token serves it
    if (shift && tok_r && pend) begin
      if (rep_r) begin
        rem_nxt = rel_r;
      end else begin
        run_nxt = 1'b0;
        rem_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rel_r <= '0;
      rep_r <= 1'b0;
      run_r <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      rel_r <= rel_nxt;
      rep_r <= rep_nxt;
      run_r <= run_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out            = tok_r;
  assign status.running     = run_r;
  assign status.pending     = pend;
  assign status.reload_zero = (rel_r == '0);
  assign status.periodic    = rep_r;

endmodule

@@ rtl/core/multi_channel_software_timer_unit.sv @@
// Top level of the multi-channel timer unit: a row of mcst_cell slots,
// the scan controller and the result register. Depends on mcst_pkg.
//
//   channel  | direction | payload     | handshake
//   ---------+-----------+-------------+-----------------------
//   in_      | input     | in_item_t   | in_valid / in_stall
//   out_     | output    | out_item_t  | out_valid / out_stall
//
// A tick decrements all running slots in its transfer cycle, then a token walks
// the cell chain one slot per cycle, except while out_stall holds back an expiry
// at the token's slot. in_stall is high while the token is in the chain.
// Synchronous reset clears every slot and the running count.
module multi_channel_software_timer_unit #(
  parameter int NUM_TIMERS  = mcst_pkg::DEF_NUM_TIMERS,
  parameter int COUNT_WIDTH = mcst_pkg::DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcst_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcst_pkg::out_item_t  out_data
);
  import mcst_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  cell_cmd_t              cmd;
  cell_status_t           status [NUM_TIMERS];
  cell_status_t           sel_status;
  logic [NUM_TIMERS-1:0]  tok;
  logic [NUM_TIMERS-1:0]  pend_vec;
  logic [NUM_TIMERS-1:0]  rep_vec;
  logic [NUM_TIMERS-1:0]  run_vec;
  logic [NUM_TIMERS:0]    low_mask;
  logic                   in_xfer, tick_acc, slot_ok;
  logic                   busy, pend_cur, rep_cur, out_free, step, emit, shift, later;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [4:0]             cnt_r, cnt_nxt, cnt_after, cnt_stop;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [31:0]            idx_ext;

  assign in_xfer  = in_valid && !in_stall;
  assign tick_acc = in_xfer && (in_data.mode == MODE_TICK);
  assign slot_ok  = (32'(in_data.slot) < NUM_TIMERS);

  // Broadcast tick and addressed command to the row
  assign cmd.tick     = tick_acc;
  assign cmd.sel      = 1'b0;
  assign cmd.mode     = in_data.mode;
  assign cmd.interval = in_data.interval;
  assign cmd.periodic = in_data.periodic;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    cell_cmd_t cmd_i;
    always_comb begin
      cmd_i     = cmd;
      cmd_i.sel = in_xfer && slot_ok && (in_data.mode != MODE_TICK) &&
                  (32'(in_data.slot) == i);
    end
    mcst_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_i),
      .tok_in  ((i == 0) ? tick_acc : tok[(i == 0) ? 0 : i-1]),
      .shift   (shift),
      .tok_out (tok[i]),
      .status  (status[i])
    );
    assign pend_vec[i] = status[i].pending;
    assign rep_vec[i]  = status[i].periodic;
    assign run_vec[i]  = status[i].running;
  end

  // Pick the addressed slot's status for the running count
  always_comb begin
    sel_status = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (32'(in_data.slot) == i) begin
        sel_status = status[i];
      end
    end
  end

  // Scan control: advance the token unless an expiry waits on the output
  assign busy     = |tok;
  assign pend_cur = |(tok & pend_vec);
  assign rep_cur  = |(tok & rep_vec);
  assign out_free = !out_valid_r || !out_stall;
  assign step     = busy && (!pend_cur || out_free);
  assign emit     = busy && pend_cur && out_free;
  assign shift    = tick_acc || step;
  assign in_stall = busy;

  // Any expiry still pending beyond the token decides the last flag
  assign low_mask = ({1'b0, tok} << 1) - 1'b1;
  assign later    = |({1'b0, pend_vec} & ~low_mask);

  assign cnt_stop = (cnt_r != 5'd0) ? (cnt_r - 5'd1) : cnt_r;

  always_comb begin
    idx_nxt = idx_r;
    if (tick_acc) begin
      idx_nxt = '0;
    end else if (step) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Track the running count through commands and one-shot expiries
  always_comb begin
    cnt_nxt   = cnt_r;
    cnt_after = rep_cur ? cnt_r : cnt_stop;
    if (emit) begin
      cnt_nxt = cnt_after;
    end else if (in_xfer && slot_ok) begin
      case (in_data.mode)
        MODE_START: begin
          if (!sel_status.running && !sel_status.reload_zero) begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        MODE_START_IVL: begin
          if (!sel_status.running && COUNT_WIDTH'(in_data.interval) != '0) begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        MODE_STOP: begin
          if (sel_status.running) begin
            cnt_nxt = cnt_stop;
          end
        end
        MODE_RESTART: begin
          cnt_nxt = (sel_status.running ? cnt_stop : cnt_r) +
                    {4'd0, !sel_status.reload_zero};
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register on an expiry, drop it once taken
  assign idx_ext = 32'(idx_r);
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.expired_slot  = idx_ext[3:0];
      out_data_nxt.last          = !later;
      out_data_nxt.running_count = cnt_after;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `MCST_ASSERT(a_tok_onehot, !busy || $onehot(tok))
  `MCST_ASSERT_NEXT(a_tick_starts_scan, tick_acc, tok[0])
  `MCST_ASSERT(a_count_matches, 32'(cnt_r) == $countones(run_vec))
  `MCST_ASSERT_NEXT(a_stall_holds_expiry, out_valid_r && out_stall && busy && pend_cur,
                    out_valid_r && $stable(out_data_r))

endmodule
